@@ src/pprs_pkg.sv @@
// Package: shared constants, types and codes for the projected point selector.
package pprs_pkg;

  localparam int unsigned CoefW   = 20;
  localparam int unsigned PosW    = 32;
  localparam int unsigned IdW     = 32;
  localparam int unsigned ClipW   = 56;
  localparam int unsigned FracW   = 20;
  localparam int unsigned ScrW    = 16;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDatW = 64;
  localparam int unsigned DivDepthDefault = 20;

  localparam logic signed [ClipW-1:0] WMinRaw = 56'sd26843;

  localparam logic [CfgIdxW-1:0] RegMat0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMat1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMat2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMat3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMat4 = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMat5 = 3'd5;
  localparam logic [CfgIdxW-1:0] RegView = 3'd6;
  localparam logic [CfgIdxW-1:0] RegRect = 3'd7;

  localparam logic [1:0] OutInside  = 2'd0;
  localparam logic [1:0] OutOutside = 2'd1;
  localparam logic [1:0] OutNoProj  = 2'd2;
  localparam logic [1:0] OutNoPos   = 2'd3;

  typedef logic signed [CoefW-1:0] coef_t;
  typedef logic signed [ClipW-1:0] clip_t;

  typedef struct packed {
    logic [IdW-1:0] id;
    logic           has_pos;
    logic           reject;
  } ctl_t;

endpackage

@@ src/pprs_if.sv @@
// Interfaces: input object channel and result channel.
interface pprs_in_if;
  logic                          valid;
  logic                          ready;
  logic [pprs_pkg::IdW-1:0]      object_id;
  logic                          has_position;
  logic signed [pprs_pkg::PosW-1:0] pos_x;
  logic signed [pprs_pkg::PosW-1:0] pos_y;
  logic signed [pprs_pkg::PosW-1:0] pos_z;
  modport source (output valid, object_id, has_position, pos_x, pos_y, pos_z, input ready);
  modport sink (input valid, object_id, has_position, pos_x, pos_y, pos_z, output ready);
endinterface

interface pprs_out_if;
  logic                          valid;
  logic                          ready;
  logic [pprs_pkg::IdW-1:0]      result_id;
  logic                          selected;
  logic [1:0]                    outcome;
  logic [pprs_pkg::ScrW-1:0]     screen_x;
  logic [pprs_pkg::ScrW-1:0]     screen_y;
  modport source (output valid, result_id, selected, outcome, screen_x, screen_y, input ready);
  modport sink (input valid, result_id, selected, outcome, screen_x, screen_y, output ready);
endinterface

@@ src/pprs_xform.sv @@
// Matrix transform: products in one stage, row sums in the next.
module pprs_xform (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_in,
  input  pprs_pkg::ctl_t                ctl_in,
  input  logic signed [pprs_pkg::PosW-1:0] px,
  input  logic signed [pprs_pkg::PosW-1:0] py,
  input  logic signed [pprs_pkg::PosW-1:0] pz,
  input  pprs_pkg::coef_t               mat [16],
  output logic                          vld_out,
  output pprs_pkg::ctl_t                ctl_out,
  output pprs_pkg::clip_t               clip [4]
);
  localparam int unsigned ProdW = pprs_pkg::CoefW + pprs_pkg::PosW;

  logic signed [ProdW-1:0] prod_r [16];
  logic                    vld1_r, vld2_r;
  pprs_pkg::ctl_t          ctl1_r, ctl2_r;
  pprs_pkg::clip_t         clip_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_in;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r <= ctl_in;
      ctl2_r <= ctl1_r;
      for (int r = 0; r < 4; r++) begin
        prod_r[r*4]   <= ProdW'(mat[r*4] * px);
        prod_r[r*4+1] <= ProdW'(mat[r*4+1] * py);
        prod_r[r*4+2] <= ProdW'(mat[r*4+2] * pz);
        // homogeneous 1.0 in Q16.16: coefficient shifted up, sign kept
        prod_r[r*4+3] <= ProdW'($signed({mat[r*4+3], 16'd0}));
        clip_r[r] <= pprs_pkg::ClipW'(prod_r[r*4]) + pprs_pkg::ClipW'(prod_r[r*4+1])
                   + pprs_pkg::ClipW'(prod_r[r*4+2]) + pprs_pkg::ClipW'(prod_r[r*4+3]);
      end
    end
  end

  assign vld_out = vld2_r;
  assign ctl_out = ctl2_r;
  assign clip    = clip_r;
endmodule

@@ src/pprs_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, Q1.Depth result (Q1.20 by default), at most 1.0.
module pprs_div #(
  parameter int unsigned Depth = pprs_pkg::DivDepthDefault
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_in,
  input  pprs_pkg::ctl_t             ctl_in,
  input  logic [pprs_pkg::ClipW-1:0] num_x,
  input  logic [pprs_pkg::ClipW-1:0] num_y,
  input  logic [pprs_pkg::ClipW-1:0] den,
  output logic                       vld_out,
  output pprs_pkg::ctl_t             ctl_out,
  output logic [Depth:0]             qx,
  output logic [Depth:0]             qy
);
  localparam int unsigned RW = pprs_pkg::ClipW + 1;

  logic              vld_r [Depth+1];
  pprs_pkg::ctl_t    ctl_r [Depth+1];
  logic [RW-1:0]     rx_r [Depth+1], ry_r [Depth+1], d_r [Depth+1];
  logic [Depth:0]    qx_r [Depth+1], qy_r [Depth+1];
  logic [RW-1:0]     sx [Depth], sy [Depth];

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      sx[i] = {rx_r[i][RW-2:0], 1'b0};
      sy[i] = {ry_r[i][RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= Depth; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_in;
      for (int i = 0; i < Depth; i++) vld_r[i+1] <= vld_r[i];
    end
  end

  // Stage 0 catches num >= den (unit result, remainder forced to zero).
  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_in;
      d_r[0]   <= {1'b0, den};
      if (num_x >= den) begin
        rx_r[0] <= '0;
        qx_r[0] <= (Depth+1)'(1);
      end else begin
        rx_r[0] <= {1'b0, num_x};
        qx_r[0] <= '0;
      end
      if (num_y >= den) begin
        ry_r[0] <= '0;
        qy_r[0] <= (Depth+1)'(1);
      end else begin
        ry_r[0] <= {1'b0, num_y};
        qy_r[0] <= '0;
      end
      for (int i = 0; i < Depth; i++) begin
        ctl_r[i+1] <= ctl_r[i];
        d_r[i+1]   <= d_r[i];
        if (sx[i] >= d_r[i]) begin
          rx_r[i+1] <= sx[i] - d_r[i];
          qx_r[i+1] <= {qx_r[i][Depth-1:0], 1'b1};
        end else begin
          rx_r[i+1] <= sx[i];
          qx_r[i+1] <= {qx_r[i][Depth-1:0], 1'b0};
        end
        if (sy[i] >= d_r[i]) begin
          ry_r[i+1] <= sy[i] - d_r[i];
          qy_r[i+1] <= {qy_r[i][Depth-1:0], 1'b1};
        end else begin
          ry_r[i+1] <= sy[i];
          qy_r[i+1] <= {qy_r[i][Depth-1:0], 1'b0};
        end
      end
    end
  end

  assign vld_out = vld_r[Depth];
  assign ctl_out = ctl_r[Depth];
  assign qx      = qx_r[Depth];
  assign qy      = qy_r[Depth];
endmodule

@@ src/projected_point_rect_select.sv @@
// Top level: projection, divide, viewport scale and rectangle test pipeline.
//
//   channel | dir | handshake          | payload
//   in_     | in  | in_if.valid/ready  | object_id, has_position, pos_x/y/z
//   out_    | out | out_if.valid/ready | result_id, selected, outcome, screen_x/y
//   cfg_    | in  | cfg_we             | cfg_idx, cfg_data
//
// One item per cycle while out is not stalled; stages are the transform, divider, scale and output registers.
// The one-quotient-bit-per-stage divider sets the depth.
// Synchronous reset clears valid bits and loads the default registers.
// A stall on out freezes the whole pipeline; the output stage holds its item.
module projected_point_rect_select #(
  parameter int unsigned DivDepth = pprs_pkg::DivDepthDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  pprs_in_if.sink                        in_if,
  pprs_out_if.source                     out_if,
  input  logic                           cfg_we,
  input  logic [pprs_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [pprs_pkg::CfgDatW-1:0]   cfg_data
);
  localparam int unsigned CW = pprs_pkg::ClipW;

  logic [59:0] mg_r [5];
  logic [19:0] m5_r;
  logic [27:0] vp_r;
  logic [63:0] rc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mg_r[0] <= 60'd4096;
      mg_r[1] <= 60'd4503599627370496;
      mg_r[2] <= '0;
      mg_r[3] <= 60'd4294967296;
      mg_r[4] <= '0;
      m5_r    <= 20'd4096;
      vp_r    <= '0;
      rc_r    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        pprs_pkg::RegMat0: mg_r[0] <= cfg_data[59:0];
        pprs_pkg::RegMat1: mg_r[1] <= cfg_data[59:0];
        pprs_pkg::RegMat2: mg_r[2] <= cfg_data[59:0];
        pprs_pkg::RegMat3: mg_r[3] <= cfg_data[59:0];
        pprs_pkg::RegMat4: mg_r[4] <= cfg_data[59:0];
        pprs_pkg::RegMat5: m5_r    <= cfg_data[19:0];
        pprs_pkg::RegView: vp_r    <= cfg_data[27:0];
        pprs_pkg::RegRect: rc_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  pprs_pkg::coef_t mat [16];
  always_comb begin
    for (int k = 0; k < 15; k++) mat[k] = mg_r[k/3][(k%3)*20 +: 20];
    mat[15] = m5_r;
  end

  logic [11:0] vw, vh;
  assign vw = vp_r[11:0];
  assign vh = vp_r[27:16];

  // Whole pipeline advances unless the output stage is full and stalled.
  logic en;
  logic ov_r;
  assign en = !ov_r || out_if.ready;
  assign in_if.ready = en;

  pprs_pkg::ctl_t ctl_in;
  assign ctl_in = '{id: in_if.object_id, has_pos: in_if.has_position, reject: 1'b0};

  logic            xv;
  pprs_pkg::ctl_t  xc;
  pprs_pkg::clip_t clip [4];

  pprs_xform u_xform (
    .clk, .rst_n, .en,
    .vld_in (in_if.valid && en),
    .ctl_in,
    .px (in_if.pos_x), .py (in_if.pos_y), .pz (in_if.pos_z),
    .mat,
    .vld_out (xv), .ctl_out (xc), .clip
  );

  // Reject test and numerators (bounded by 2w when accepted).
  pprs_pkg::clip_t w, nw;
  logic            rej;
  pprs_pkg::ctl_t  dc_in;
  logic [CW-1:0]   nx, ny, dd;
  always_comb begin
    w   = clip[3];
    nw  = -w;
    rej = (vw == '0) || (vh == '0) || (w <= pprs_pkg::WMinRaw)
       || (clip[0] < nw) || (clip[0] > w) || (clip[1] < nw) || (clip[1] > w)
       || (clip[2] < nw) || (clip[2] > w);
    dc_in = xc;
    dc_in.reject = rej;
    nx = rej ? '0 : CW'(clip[0] + w);
    ny = rej ? '0 : CW'(w - clip[1]);
    dd = rej ? CW'(1) : CW'({w[CW-2:0], 1'b0});
  end

  logic            dv;
  pprs_pkg::ctl_t  dcc;
  logic [DivDepth:0] qx, qy;

  pprs_div #(.Depth(DivDepth)) u_div (
    .clk, .rst_n, .en,
    .vld_in (xv), .ctl_in (dc_in),
    .num_x (nx), .num_y (ny), .den (dd),
    .vld_out (dv), .ctl_out (dcc), .qx, .qy
  );

  // Scale stage: t * size * 16 >> frac.
  localparam int unsigned MW = DivDepth + 1 + 12 + 4;
  logic [MW-1:0] mx_r, my_r;
  logic          sv_r;
  pprs_pkg::ctl_t sc_r;
  always_ff @(posedge clk) begin
    if (!rst_n) sv_r <= 1'b0;
    else if (en) sv_r <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sc_r <= dcc;
      mx_r <= MW'(qx * {vw, 4'd0});
      my_r <= MW'(qy * {vh, 4'd0});
    end
  end

  logic [pprs_pkg::ScrW-1:0] sx, sy;
  assign sx = pprs_pkg::ScrW'(mx_r >> DivDepth);
  assign sy = pprs_pkg::ScrW'(my_r >> DivDepth);

  logic [15:0] ax, ay, bx, by, x0, x1, y0, y1;
  always_comb begin
    ax = rc_r[15:0];  ay = rc_r[31:16];
    bx = rc_r[47:32]; by = rc_r[63:48];
    x0 = (ax < bx) ? ax : bx;  x1 = (ax < bx) ? bx : ax;
    y0 = (ay < by) ? ay : by;  y1 = (ay < by) ? by : ay;
  end

  logic [pprs_pkg::IdW-1:0]  oid_r;
  logic                      osel_r;
  logic [1:0]                ooc_r;
  logic [pprs_pkg::ScrW-1:0] osx_r, osy_r;
  logic                      in_rect;
  assign in_rect = (sx >= x0) && (sx <= x1) && (sy >= y0) && (sy <= y1);

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= sv_r;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      oid_r <= sc_r.id;
      priority if (!sc_r.has_pos) begin
        ooc_r <= pprs_pkg::OutNoPos;  osel_r <= 1'b0; osx_r <= '0; osy_r <= '0;
      end else if (sc_r.reject) begin
        ooc_r <= pprs_pkg::OutNoProj; osel_r <= 1'b0; osx_r <= '0; osy_r <= '0;
      end else begin
        ooc_r  <= in_rect ? pprs_pkg::OutInside : pprs_pkg::OutOutside;
        osel_r <= in_rect;
        osx_r  <= sx;
        osy_r  <= sy;
      end
    end
  end

  assign out_if.valid     = ov_r;
  assign out_if.result_id = oid_r;
  assign out_if.selected  = osel_r;
  assign out_if.outcome   = ooc_r;
  assign out_if.screen_x  = osx_r;
  assign out_if.screen_y  = osy_r;
endmodule

@@ src/pprs_chk.sv @@
// Port checker for the projected point selector, bound to the top level.
module pprs_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       selected,
  input logic [1:0] outcome,
  input logic [15:0] screen_x,
  input logic [15:0] screen_y
);
  a_sel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (selected == (outcome == pprs_pkg::OutInside))) else $error("sel");
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (outcome == pprs_pkg::OutNoPos || outcome == pprs_pkg::OutNoProj)
    |-> (screen_x == 16'd0 && screen_y == 16'd0)) else $error("zero");
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready) else $error("rdy");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(outcome))) else $error("hold");
endmodule

bind projected_point_rect_select pprs_chk u_chk (
  .clk, .rst_n,
  .in_ready (in_if.ready),
  .out_valid (out_if.valid), .out_ready (out_if.ready),
  .selected (out_if.selected), .outcome (out_if.outcome),
  .screen_x (out_if.screen_x), .screen_y (out_if.screen_y)
);
